@@ rtl/msp_pkg.sv @@
// shared types and constants for the multi-channel servo pulse generator
// no dependencies; imported by every module of the block
`default_nettype none

package msp_pkg;

    // default build sizes
    localparam int NUM_SERVOS_DEF   = 18;
    localparam int COUNTER_BITS_DEF = 16;

    // fixed field widths
    localparam int PIN_W      = 18;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 8;
    localparam int NUM_W      = 5;
    localparam int HDR_W      = 7;
    localparam int PERIOD_W   = 16;
    localparam int BASE_W     = 16;
    localparam int STEP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;

    // header byte layout
    localparam int HDR_FLAG_BIT = 7;
    localparam int POS_MSB_BIT  = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;

    // register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd10000;
    localparam logic [BASE_W-1:0]   BASE_RST   = 16'd500;
    localparam logic [STEP_W-1:0]   STEP_RST   = 8'd1;

    // item kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    // per-transaction control carried down the cell chain
    typedef struct packed {
        logic             wr_en;
        logic [NUM_W-1:0] wr_num;
        logic [POS_W-1:0] wr_pos;
        logic             accepted;
        logic             rejected;
    } t_token;

endpackage

`default_nettype wire

@@ rtl/multi_servo_pwm_with_serial_commands.sv @@
// top level of the multi-channel servo pulse generator with serial command parser
// depends on msp_pkg, msp_head and msp_cell
`default_nettype none

// Each input transaction is either a timer tick (tuser = 0) or one received serial
// byte (tuser = 1, byte in tdata). A tick advances the frame counter, which wraps at
// period_ticks; a header byte (bit 7 clear, bits 4:0 = servo 1..NUM_SERVOS, bit 6 =
// position bit 7) followed by a data byte (position bits 6:0) sets one servo's
// position. Every transaction yields exactly one result with the pin levels after
// it: a pin is high while the counter is below pulse_base + position * step_ticks.
// One transaction is taken every clock cycle unless the chain is held; each result
// appears after the transaction walks the head stage and then one cell per servo,
// each cell applying any write aimed at it and adding its own pin bit. The whole
// chain holds while a result waits on m_axis_tready. The user must write registers
// through the plain write port only while the block is idle; the block does not enforce it.

module multi_servo_pwm_with_serial_commands #(
    parameter int NUM_SERVOS   = msp_pkg::NUM_SERVOS_DEF,
    parameter int COUNTER_BITS = msp_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [msp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [msp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [msp_pkg::S_DATA_W-1:0]     s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                             s_axis_tuser,  // [0] opcode
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [msp_pkg::M_DATA_W-1:0]          m_axis_tdata   // [17:0] pin_levels,
                                                                  // [18] cmd_accepted,
                                                                  // [19] cmd_rejected
);
    import msp_pkg::*;

    // configuration registers
    logic [PERIOD_W-1:0] r_period;
    logic [BASE_W-1:0]   r_base;
    logic [STEP_W-1:0]   r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_base   <= BASE_RST;
            r_step   <= STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_BASE:   r_base   <= i_cfg_data[BASE_W-1:0];
                CFG_STEP:   r_step   <= i_cfg_data[STEP_W-1:0];
                default:    ;  // index beyond the list is ignored
            endcase
        end
    end

    // chain links: stage 0 is the head output, stage NUM_SERVOS the result
    logic                    ch_valid [NUM_SERVOS+1];
    t_token                  ch_tok   [NUM_SERVOS+1];
    logic [COUNTER_BITS-1:0] ch_cnt   [NUM_SERVOS+1];
    logic [NUM_SERVOS-1:0]   ch_pins  [NUM_SERVOS+1];

    // whole chain moves together unless a result is held
    logic en;
    assign en            = !ch_valid[NUM_SERVOS] || m_axis_tready;
    assign s_axis_tready = en;

    msp_head #(
        .NUM_SERVOS   (NUM_SERVOS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_head (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (s_axis_tvalid),
        .i_opcode (s_axis_tuser),
        .i_byte   (s_axis_tdata[BYTE_W-1:0]),
        .i_period (r_period),
        .o_valid  (ch_valid[0]),
        .o_tok    (ch_tok[0]),
        .o_cnt    (ch_cnt[0])
    );

    assign ch_pins[0] = '0;

    for (genvar g = 0; g < NUM_SERVOS; g++) begin : g_cell
        msp_cell #(
            .NUM_SERVOS   (NUM_SERVOS),
            .COUNTER_BITS (COUNTER_BITS),
            .IDX          (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (ch_valid[g]),
            .i_tok   (ch_tok[g]),
            .i_cnt   (ch_cnt[g]),
            .i_pins  (ch_pins[g]),
            .i_base  (r_base),
            .i_step  (r_step),
            .o_valid (ch_valid[g+1]),
            .o_tok   (ch_tok[g+1]),
            .o_cnt   (ch_cnt[g+1]),
            .o_pins  (ch_pins[g+1])
        );
    end

    // pin field is fixed width; servos beyond it are dropped, missing ones read zero
    logic [NUM_SERVOS+PIN_W-1:0] pins_pad;
    t_token                      out_tok;

    assign pins_pad      = {{PIN_W{1'b0}}, ch_pins[NUM_SERVOS]};
    assign out_tok       = ch_tok[NUM_SERVOS];
    assign m_axis_tvalid = ch_valid[NUM_SERVOS];
    assign m_axis_tdata  = {{(M_DATA_W - PIN_W - 2){1'b0}}, out_tok.rejected,
                            out_tok.accepted, pins_pad[PIN_W-1:0]};

    // ---------------------------------------------------------------- assertions

    localparam int AW = (COUNTER_BITS > PERIOD_W) ? COUNTER_BITS : PERIOD_W;

    logic [AW-1:0] per_eff;
    assign per_eff = (r_period == '0) ? AW'(1) : AW'(r_period);

    // a result never claims both acceptance and rejection
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(out_tok.accepted && out_tok.rejected))
        else $error("result flags both set");

    // after an accepted tick the frame counter sits below the effective period
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_TICK)
        |=> (AW'(ch_cnt[0]) < $past(per_eff)))
        else $error("frame counter beyond period after tick");

    // a write token only travels with an accepted command
    a_wr_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ch_valid[0] |-> (ch_tok[0].wr_en == ch_tok[0].accepted))
        else $error("position write without accepted command");

endmodule

`default_nettype wire

@@ rtl/msp_head.sv @@
// head stage: frame counter and two-byte command parser
// depends on msp_pkg
`default_nettype none

module msp_head #(
    parameter int NUM_SERVOS   = msp_pkg::NUM_SERVOS_DEF,
    parameter int COUNTER_BITS = msp_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire logic                           i_opcode,
    input  wire logic [msp_pkg::BYTE_W-1:0]     i_byte,
    input  wire logic [msp_pkg::PERIOD_W-1:0]   i_period,
    output logic                                o_valid,
    output msp_pkg::t_token                     o_tok,
    output logic [COUNTER_BITS-1:0]             o_cnt
);
    import msp_pkg::*;

    localparam int CW = (COUNTER_BITS + 1 > PERIOD_W) ? COUNTER_BITS + 1 : PERIOD_W;

    logic                    r_valid;
    t_token                  r_tok;
    logic [COUNTER_BITS-1:0] r_cnt;
    logic [HDR_W-1:0]        r_hdr;
    logic                    r_hdr_vld;

    logic [CW-1:0]           inc;
    logic [CW-1:0]           per;
    logic [COUNTER_BITS-1:0] n_cnt;
    logic [NUM_W-1:0]        num;
    logic                    num_ok;
    t_token                  n_tok;

    always_comb begin
        inc   = CW'(r_cnt) + CW'(1);
        per   = (i_period == '0) ? CW'(1) : CW'(i_period);
        n_cnt = (inc >= per) ? '0 : inc[COUNTER_BITS-1:0];
        num   = r_hdr[NUM_W-1:0];
        num_ok = (num != '0) && ({1'b0, num} <= (NUM_W + 1)'(NUM_SERVOS));
        // a data byte completes the command held in the header register
        n_tok = '0;
        if (i_opcode == OP_BYTE && r_hdr_vld) begin
            if (num_ok) begin
                n_tok.wr_en    = 1'b1;
                n_tok.wr_num   = num;
                n_tok.wr_pos   = {r_hdr[POS_MSB_BIT], i_byte[POS_W-2:0]};
                n_tok.accepted = 1'b1;
            end else begin
                n_tok.rejected = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_cnt     <= '0;
            r_hdr     <= '0;
            r_hdr_vld <= 1'b0;
            r_tok     <= '0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_tok <= n_tok;
                if (i_opcode == OP_TICK) begin
                    r_cnt <= n_cnt;
                end else if (!r_hdr_vld) begin
                    // bytes with the top bit set are dropped while awaiting a header
                    if (!i_byte[HDR_FLAG_BIT]) begin
                        r_hdr     <= i_byte[HDR_W-1:0];
                        r_hdr_vld <= 1'b1;
                    end
                end else begin
                    r_hdr_vld <= 1'b0;
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_cnt   = r_cnt;

endmodule

`default_nettype wire

@@ rtl/msp_cell.sv @@
// one servo cell: holds a position, applies writes and sets its pin bit
// depends on msp_pkg
`default_nettype none

module msp_cell #(
    parameter int NUM_SERVOS   = msp_pkg::NUM_SERVOS_DEF,
    parameter int COUNTER_BITS = msp_pkg::COUNTER_BITS_DEF,
    parameter int IDX          = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire msp_pkg::t_token               i_tok,
    input  wire logic [COUNTER_BITS-1:0]       i_cnt,
    input  wire logic [NUM_SERVOS-1:0]         i_pins,
    input  wire logic [msp_pkg::BASE_W-1:0]    i_base,
    input  wire logic [msp_pkg::STEP_W-1:0]    i_step,
    output logic                               o_valid,
    output msp_pkg::t_token                    o_tok,
    output logic [COUNTER_BITS-1:0]            o_cnt,
    output logic [NUM_SERVOS-1:0]              o_pins
);
    import msp_pkg::*;

    // threshold needs base plus a 16-bit product without overflow
    localparam int TW = ((COUNTER_BITS > BASE_W + 1) ? COUNTER_BITS : BASE_W + 1) + 1;

    logic                    r_valid;
    t_token                  r_tok;
    logic [COUNTER_BITS-1:0] r_cnt;
    logic [NUM_SERVOS-1:0]   r_pins;
    logic [POS_W-1:0]        r_pos;

    logic                      hit;
    logic [POS_W-1:0]          pos_now;
    logic [POS_W+STEP_W-1:0]   prod;
    logic [TW-1:0]             thr;
    logic [NUM_SERVOS-1:0]     n_pins;

    always_comb begin
        hit     = i_valid && i_tok.wr_en && (i_tok.wr_num == NUM_W'(IDX + 1));
        pos_now = hit ? i_tok.wr_pos : r_pos;
        prod    = pos_now * i_step;
        thr     = TW'(i_base) + TW'(prod);
        n_pins  = i_pins;
        n_pins[IDX] = TW'(i_cnt) < thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (i_en) begin
            r_valid <= i_valid;
            r_tok   <= i_tok;
            r_cnt   <= i_cnt;
            r_pins  <= n_pins;
            if (hit) begin
                r_pos <= i_tok.wr_pos;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;
    assign o_cnt   = r_cnt;
    assign o_pins  = r_pins;

endmodule

`default_nettype wire
